// File: hdl/tmlc_pkg.sv
// ----------------------------------------------------------------------------
// tmlc_pkg
// shared widths, reset values and register indexes of the light classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmlc_pkg;

  localparam int SHIFT       = 4;
  localparam int SAMPLE_BITS = 12;
  localparam int KEPT_COUNT  = (1 << SHIFT) + 2;
  localparam int IDX_W       = $clog2(KEPT_COUNT + 1);

  localparam int SUM_MAX = KEPT_COUNT * ((1 << (SAMPLE_BITS - SHIFT)) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  localparam int THR_W    = 16;
  localparam int SERIES_W = 8;
  localparam int REF_W    = 16;
  localparam int CODE_W   = 12;
  localparam int CFG_W    = 16;
  localparam int MV_W     = 16;
  localparam int RES_W    = 16;

  // serial multiply: multiplier is at most CODE_W bits wide
  localparam int MUL_STEPS = CODE_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int PROD_W    = (SUM_W + CODE_W > SERIES_W + MV_W) ?
                             SUM_W + CODE_W : SERIES_W + MV_W;

  // serial divider sized for the wider of both divisions
  localparam int DIVISOR_W = REF_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam logic [DIVISOR_W-1:0] UV_PER_MV = DIVISOR_W'(1000);

  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(25);
  localparam logic [SERIES_W-1:0] SERIES_RESET = SERIES_W'(10);
  localparam logic [REF_W-1:0]    REF_RESET    = REF_W'(3300);
  localparam logic [CODE_W-1:0]   CODE_RESET   = CODE_W'(806);

  typedef enum logic [1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_SERIES     = 2'd1,
    CFG_REF_MV     = 2'd2,
    CFG_CODE_TO_UV = 2'd3
  } cfg_addr_e;

endpackage

// File: hdl/tmlc_serdiv.sv
// ----------------------------------------------------------------------------
// tmlc_serdiv
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmlc_serdiv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tmlc_pkg::PROD_W-1:0]    dividend_i,
  input  logic [tmlc_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [tmlc_pkg::PROD_W-1:0]    quotient_o
);
  import tmlc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/trimmed_mean_light_classifier.sv
// ----------------------------------------------------------------------------
// trimmed_mean_light_classifier
// trimmed-mean light sensor filter with day / night decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A measurement is 19 sample transfers: the first is a warm-up code and is
// dropped, the next 18 are summed as sample>>4 while min and max are tracked.
// After the 18th kept sample the input stalls while the result is computed
// bit-serially: a 12-step shift-add multiply and a 25-step restoring divide
// by 1000, then a compare. At or above the reference that is the end and the
// result is handed over. Below the reference a second 12-step multiply and a
// divide by (ref - mv) follow. Both divisions go through one shared
// one-bit-per-cycle divider. The stall grows only while the output register
// still holds an unread result. The result sits in an output register, so the
// next measurement is collected while it waits for transfer. Configuration
// writes are applied at once and should be made between measurements.

module trimmed_mean_light_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [tmlc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tmlc_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tmlc_pkg::MV_W-1:0]     voltage_mv_o,
  output logic [tmlc_pkg::RES_W-1:0]    resistance_kohm_o,
  output logic                          is_night_o
);
  import tmlc_pkg::*;

  typedef enum logic [6:0] {
    S_COLLECT = 7'b0000001,
    S_MUL1    = 7'b0000010,
    S_DIV1    = 7'b0000100,
    S_CHECK   = 7'b0001000,
    S_MUL2    = 7'b0010000,
    S_DIV2    = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_e;

  // configuration registers
  logic [THR_W-1:0]    thr_q;
  logic [SERIES_W-1:0] series_q;
  logic [REF_W-1:0]    ref_q;
  logic [CODE_W-1:0]   code_q;

  state_e state_q, state_d;

  // sample accumulation
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [SAMPLE_BITS-1:0] min_nxt, max_nxt;
  logic [SUM_W-1:0]       sum_nxt, avg;

  // shift-add multiplier
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [CODE_W-1:0]    mplier_q, mplier_d;
  logic [MUL_CNT_W-1:0] mcnt_q, mcnt_d;

  // divider hookup
  logic                 start_q, start_d;
  logic [DIVISOR_W-1:0] divisor;
  logic                 div_done;
  logic [PROD_W-1:0]    quotient;
  logic [MV_W-1:0]      quo_sat;

  // result
  logic [MV_W-1:0]  mv_q, mv_d;
  logic [RES_W-1:0] res_q, res_d;
  logic             night_q, night_d;
  logic             ovalid_q, ovalid_d;
  logic [MV_W-1:0]  omv_q, omv_d;
  logic [RES_W-1:0] ores_q, ores_d;
  logic             onight_q, onight_d;

  logic in_xfer;

  assign in_stall_o = (state_q != S_COLLECT);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // running min / max / sum including the current sample
  always_comb begin
    if (idx_q == IDX_W'(1)) begin
      min_nxt = sample_i;
      max_nxt = sample_i;
    end else begin
      min_nxt = (sample_i < min_q) ? sample_i : min_q;
      max_nxt = (sample_i > max_q) ? sample_i : max_q;
    end
    sum_nxt = sum_q + SUM_W'(sample_i >> SHIFT);
    avg     = sum_nxt - SUM_W'(max_nxt >> SHIFT) - SUM_W'(min_nxt >> SHIFT);
  end

  // divide by 1000 for millivolts, then by the voltage left across the series resistor
  assign divisor = (state_q == S_DIV1) ? UV_PER_MV : (ref_q - mv_q);
  assign quo_sat = (|quotient[PROD_W-1:MV_W]) ? {MV_W{1'b1}} : quotient[MV_W-1:0];

  tmlc_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (prod_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    min_d    = min_q;
    max_d    = max_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    mcnt_d   = mcnt_q;
    start_d  = 1'b0;
    mv_d     = mv_q;
    res_d    = res_q;
    night_d  = night_q;
    ovalid_d = ovalid_q && out_stall_i;
    omv_d    = omv_q;
    ores_d   = ores_q;
    onight_d = onight_q;

    case (state_q)
      S_COLLECT: begin
        if (in_xfer) begin
          if (idx_q == '0) begin
            // warm-up conversion is dropped
            idx_d = IDX_W'(1);
          end else begin
            min_d = min_nxt;
            max_d = max_nxt;
            if (idx_q < IDX_W'(KEPT_COUNT)) begin
              sum_d = sum_nxt;
              idx_d = idx_q + 1'b1;
            end else begin
              // last kept sample: start avg * code_to_uv
              idx_d    = '0;
              sum_d    = '0;
              prod_d   = '0;
              mcand_d  = PROD_W'(avg);
              mplier_d = code_q;
              mcnt_d   = '0;
              state_d  = S_MUL1;
            end
          end
        end
      end
      S_MUL1, S_MUL2: begin
        if (mplier_q[0]) prod_d = prod_q + mcand_q;
        mcand_d  = {mcand_q[PROD_W-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        mcnt_d   = mcnt_q + 1'b1;
        if (mcnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
          start_d = 1'b1;
          state_d = (state_q == S_MUL1) ? S_DIV1 : S_DIV2;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          mv_d    = quo_sat;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mv_q >= ref_q) begin
          // at or above the reference: clamp and call it night
          mv_d    = ref_q;
          res_d   = {RES_W{1'b1}};
          night_d = 1'b1;
          state_d = S_OUT;
        end else begin
          prod_d   = '0;
          mcand_d  = PROD_W'(mv_q);
          mplier_d = CODE_W'(series_q);
          mcnt_d   = '0;
          state_d  = S_MUL2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          res_d   = quo_sat;
          night_d = (quo_sat > thr_q);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hand over once the output register is free
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          omv_d    = mv_q;
          ores_d   = res_q;
          onight_d = night_q;
          state_d  = S_COLLECT;
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_COLLECT;
      idx_q    <= '0;
      sum_q    <= '0;
      start_q  <= 1'b0;
      ovalid_q <= 1'b0;
      thr_q    <= THR_RESET;
      series_q <= SERIES_RESET;
      ref_q    <= REF_RESET;
      code_q   <= CODE_RESET;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      start_q  <= start_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_addr_e'(cfg_addr_i))
          CFG_THRESHOLD:  thr_q    <= cfg_wdata_i[THR_W-1:0];
          CFG_SERIES:     series_q <= cfg_wdata_i[SERIES_W-1:0];
          CFG_REF_MV:     ref_q    <= cfg_wdata_i[REF_W-1:0];
          CFG_CODE_TO_UV: code_q   <= cfg_wdata_i[CODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    max_q    <= max_d;
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    mcnt_q   <= mcnt_d;
    mv_q     <= mv_d;
    res_q    <= res_d;
    night_q  <= night_d;
    omv_q    <= omv_d;
    ores_q   <= ores_d;
    onight_q <= onight_d;
  end

  assign out_valid_o       = ovalid_q;
  assign voltage_mv_o      = omv_q;
  assign resistance_kohm_o = ores_q;
  assign is_night_o        = onight_q;

endmodule

// File: tb/tmlc_checker.sv
// ----------------------------------------------------------------------------
// tmlc_checker
// watches the light classifier ports, predicts every reading and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmlc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_addr_i,
  input  logic [tmlc_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [tmlc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [tmlc_pkg::MV_W-1:0]        voltage_mv_i,
  input  logic [tmlc_pkg::RES_W-1:0]       resistance_kohm_i,
  input  logic                             is_night_i,
  output int                               error_count_o,
  output int                               pending_o
);

  import tmlc_pkg::*;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [RES_W-1:0] resistance_kohm;
    logic             is_night;
  } light_reading_t;

  // shadow copy of the registers
  logic [THR_W-1:0]    threshold_kohm;
  logic [SERIES_W-1:0] series_kohm;
  logic [REF_W-1:0]    ref_mv;
  logic [CODE_W-1:0]   uv_per_code;

  // measurement in progress
  logic [IDX_W-1:0]       sample_index;
  logic [SUM_W-1:0]       scaled_sum;
  logic [SAMPLE_BITS-1:0] lowest_code;
  logic [SAMPLE_BITS-1:0] highest_code;

  light_reading_t expected_readings[$];
  int             mismatches = 0;

  function automatic light_reading_t classify_reading(input logic [SUM_W-1:0] trimmed_sum);
    logic [63:0]    mv;
    logic [63:0]    res;
    light_reading_t r;
    mv = (64'(trimmed_sum) * 64'(uv_per_code)) / 64'(UV_PER_MV);
    if (mv > 64'hFFFF) mv = 64'hFFFF;
    if (mv >= 64'(ref_mv)) begin
      r.voltage_mv      = ref_mv;
      r.resistance_kohm = '1;
      r.is_night        = 1'b1;
    end else begin
      res = (64'(series_kohm) * mv) / (64'(ref_mv) - mv);
      if (res > 64'hFFFF) res = 64'hFFFF;
      r.voltage_mv      = mv[MV_W-1:0];
      r.resistance_kohm = res[RES_W-1:0];
      r.is_night        = res > 64'(threshold_kohm);
    end
    return r;
  endfunction

  // one accepted code; a reading is queued on the last kept sample
  task automatic absorb_code(input logic [SAMPLE_BITS-1:0] code);
    if (sample_index == '0) begin
      sample_index = IDX_W'(1);  // warm-up code is dropped
    end else begin
      if (sample_index == IDX_W'(1)) begin
        lowest_code  = code;
        highest_code = code;
      end else begin
        if (code < lowest_code)  lowest_code  = code;
        if (code > highest_code) highest_code = code;
      end
      scaled_sum = scaled_sum + SUM_W'(code >> SHIFT);
      if (sample_index < IDX_W'(KEPT_COUNT)) begin
        sample_index = sample_index + IDX_W'(1);
      end else begin
        expected_readings.push_back(classify_reading(scaled_sum
                                                     - SUM_W'(highest_code >> SHIFT)
                                                     - SUM_W'(lowest_code >> SHIFT)));
        sample_index = '0;
        scaled_sum   = '0;
      end
    end
  endtask

  task automatic compare_reading();
    light_reading_t want;
    if (expected_readings.size() == 0) begin
      $error("reading transfer with nothing expected: voltage_mv %0d", voltage_mv_i);
      mismatches++;
    end else begin
      want = expected_readings.pop_front();
      if (voltage_mv_i !== want.voltage_mv) begin
        $error("voltage_mv: expected %0d, got %0d", want.voltage_mv, voltage_mv_i);
        mismatches++;
      end
      if (resistance_kohm_i !== want.resistance_kohm) begin
        $error("resistance_kohm: expected %0d, got %0d", want.resistance_kohm,
               resistance_kohm_i);
        mismatches++;
      end
      if (is_night_i !== want.is_night) begin
        $error("is_night: expected %0d, got %0d", want.is_night, is_night_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_kohm = THR_RESET;
      series_kohm    = SERIES_RESET;
      ref_mv         = REF_RESET;
      uv_per_code    = CODE_RESET;
      sample_index   = '0;
      scaled_sum     = '0;
      lowest_code    = '0;
      highest_code   = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_addr_e'(cfg_addr_i))
          CFG_THRESHOLD:  threshold_kohm = cfg_wdata_i[THR_W-1:0];
          CFG_SERIES:     series_kohm    = cfg_wdata_i[SERIES_W-1:0];
          CFG_REF_MV:     ref_mv         = cfg_wdata_i[REF_W-1:0];
          CFG_CODE_TO_UV: uv_per_code    = cfg_wdata_i[CODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) compare_reading();
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) absorb_code(sample_i);
    end
    error_count_o <= mismatches;
    pending_o     <= expected_readings.size();
  end

endmodule

// File: tb/tb_trimmed_mean_light_classifier.sv
// ----------------------------------------------------------------------------
// tb_trimmed_mean_light_classifier
// feeds whole measurements of ADC codes through the light classifier under
// several register settings, with bursty input and a stalling receiver; the
// checker predicts every reading and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trimmed_mean_light_classifier;

  import tmlc_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int PHASE_READINGS = 9;      // measurements per register setting
  localparam int SETTINGS_COUNT = 8;
  localparam int DRAIN_CYCLES   = 150;    // well past the compute of one measurement
  localparam int TIMEOUT_CYCLES = 400000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  cfg_addr_e              cfg_addr  = CFG_THRESHOLD;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] sample    = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MV_W-1:0]        voltage_mv;
  logic [RES_W-1:0]       resistance_kohm;
  logic                   is_night;

  int mismatch_count;
  int readings_pending;

  // sender burst state
  int burst_left = 1;

  // receiver stall pattern state
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_hold = 0;
  int          stall_tick = 0;

  int cycle_count = 0;

  // one hand-picked measurement: the warm-up slot holds full scale, the kept
  // slots hit both code extremes, shift boundaries and repeated min / max
  logic [SAMPLE_BITS-1:0] corner_codes [KEPT_COUNT + 1] = '{
    12'd4095, 12'd0,    12'd4095, 12'd4095, 12'd0,    12'd2048, 12'd1,
    12'd4094, 12'd15,   12'd16,   12'd2047, 12'd4080, 12'd4095, 12'd0,
    12'd100,  12'd3000, 12'd1234, 12'd17,   12'd4095
  };

  always #(HALF_PERIOD) clk = ~clk;

  trimmed_mean_light_classifier dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .sample_i          (sample),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .voltage_mv_o      (voltage_mv),
    .resistance_kohm_o (resistance_kohm),
    .is_night_o        (is_night)
  );

  tmlc_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .sample_i          (sample),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .voltage_mv_i      (voltage_mv),
    .resistance_kohm_i (resistance_kohm),
    .is_night_i        (is_night),
    .error_count_o     (mismatch_count),
    .pending_o         (readings_pending)
  );

  // receiver: switches between randomly chosen stall patterns,
  // including long stretches with no stall at all
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(20, 300);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  // watchdog: a hung handshake or a missing reading ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one sample transfer; valid stays up across a burst and only drops
  // when a gap is chosen, so a gap can land on any slot of a measurement
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] code);
    int gap;
    in_valid <= 1'b1;
    sample   <= code;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 7) == 0) begin
        // long run with no idle cycles
        burst_left = $urandom_range(40, 120);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(0, 8);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        sample   <= SAMPLE_BITS'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // a full measurement: warm-up code plus every kept code; the level sweeps
  // the whole code range so readings fall on both sides of the reference
  // and of the night threshold
  task automatic send_measurement();
    int shape;
    int level;
    int spread;
    int code;
    shape  = $urandom_range(0, 3);
    level  = $urandom_range(0, 4095);
    spread = $urandom_range(0, 400);
    for (int n = 0; n < KEPT_COUNT + 1; n++) begin
      case (shape)
        0:       code = $urandom_range(0, 4095);
        1:       code = level;
        default: code = level + int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      // occasional spikes so the trimmed min / max actually matter
      if (shape == 3 && $urandom_range(0, 5) == 0) code = $urandom_range(0, 1) ? 4095 : 0;
      if (code < 0)    code = 0;
      if (code > 4095) code = 4095;
      send_sample(SAMPLE_BITS'(code));
    end
  endtask

  // back to idle: wait for every outstanding reading, then let the block
  // finish anything it may still be computing
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all four registers back to back, one per cycle; unused upper data bits
  // carry random junk that the block must drop
  task automatic write_config(input logic [THR_W-1:0]    thr,
                              input logic [SERIES_W-1:0] series,
                              input logic [REF_W-1:0]    ref_level,
                              input logic [CODE_W-1:0]   uv);
    logic [CFG_W-1:0] vals [4];
    vals[CFG_THRESHOLD]  = thr;
    vals[CFG_SERIES]     = {8'($urandom), series};
    vals[CFG_REF_MV]     = ref_level;
    vals[CFG_CODE_TO_UV] = {4'($urandom), uv};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_addr_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first, starting with the corner measurement
    for (int n = 0; n < KEPT_COUNT + 1; n++) send_sample(corner_codes[n]);
    repeat (PHASE_READINGS) send_measurement();

    for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
      settle();
      case (setting)
        // widest divider, huge reference: always below it, night for any nonzero resistance
        0: write_config('0, '1, '1, '1);
        // zero scale: voltage is zero, resistance zero, always day
        1: write_config('1, '0, 16'd1, '0);
        // zero reference: every voltage counts as at or above it
        2: write_config(16'd100, 8'd200, 16'd0, 12'd2000);
        // low reference so many readings clamp to it
        3: write_config(16'($urandom_range(0, 60)), 8'($urandom), 16'($urandom_range(1, 800)),
                        12'($urandom_range(500, 4095)));
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            write_config(16'($urandom_range(0, 300)), 8'($urandom),
                         16'($urandom_range(1000, 6000)), 12'($urandom_range(300, 1500)));
          end else begin
            write_config(16'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)),
                         12'($urandom));
          end
        end
      endcase
      repeat (PHASE_READINGS) send_measurement();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tmlc_pkg.sv
hdl/tmlc_serdiv.sv
hdl/trimmed_mean_light_classifier.sv
tb/tmlc_checker.sv
tb/tb_trimmed_mean_light_classifier.sv
